/* hdl/v3alu_pkg.sv */
// ----------------------------------------------------------------------------
// v3alu_pkg: shared types and constants of the vector ALU
// Format constants, operation codes, stage counts and the saturation helper.
// ----------------------------------------------------------------------------
package v3alu_pkg;

   localparam int WORD_BITS   = 32;
   localparam int FRAC_BITS   = 16;
   localparam int OPD_BITS    = WORD_BITS + 1;        // multiplier operand
   localparam int PROD_BITS   = 2 * OPD_BITS;         // one product
   localparam int LANE_BITS   = PROD_BITS + 1;        // sum of two products
   localparam int SUM_BITS    = PROD_BITS + 2;        // sum of three lanes
   localparam int RAD_BITS    = 2 * WORD_BITS;        // square-sum radicand
   localparam int ROOT_BITS   = WORD_BITS;
   localparam int SQRT_STAGES = ROOT_BITS / 2;        // two root bits a stage
   localparam int NUM_BITS    = WORD_BITS + FRAC_BITS;
   localparam int DIV_STAGES  = NUM_BITS / 2;         // two quotient bits a stage

   localparam logic signed [SUM_BITS-1:0] SAT_MAX =
      (SUM_BITS'(1) <<< (WORD_BITS - 1)) - SUM_BITS'(1);
   localparam logic signed [SUM_BITS-1:0] SAT_MIN = -SAT_MAX - SUM_BITS'(1);
   localparam logic [WORD_BITS-1:0] WORD_MAX = {1'b0, {(WORD_BITS-1){1'b1}}};
   localparam logic [WORD_BITS-1:0] WORD_MIN = {1'b1, {(WORD_BITS-1){1'b0}}};

   typedef logic signed [WORD_BITS-1:0] word_type;

   typedef enum logic [3:0] {
      OP_ADD   = 4'd0,
      OP_SUB   = 4'd1,
      OP_MUL   = 4'd2,
      OP_DIV   = 4'd3,
      OP_SADD  = 4'd4,
      OP_SMUL  = 4'd5,
      OP_DOT   = 4'd6,
      OP_CROSS = 4'd7,
      OP_LEN   = 4'd8,
      OP_DIST  = 4'd9,
      OP_NORM  = 4'd10,
      OP_INV   = 4'd11,
      OP_LERP  = 4'd12
   } op_type;

   // beat state carried alongside the square root
   typedef struct packed {
      op_type                         act;
      logic [2:0][WORD_BITS-1:0]      r;
      logic [WORD_BITS-1:0]           so;
      logic                           st;
      logic [2:0][WORD_BITS-1:0]      a;
      logic [2:0][WORD_BITS-1:0]      b;
   } side_type;

   // beat state carried alongside the dividers
   typedef struct packed {
      op_type                         act;
      logic [2:0][WORD_BITS-1:0]      r;
      logic [WORD_BITS-1:0]           so;
      logic                           st;
      logic                           dz;
      logic [2:0]                     neg;
      logic [2:0]                     dzero;
      logic [2:0]                     dzneg;
      logic                           lzero;
   } fin_type;

   // clamp to the word range; top bit of the result is the clamp flag
   function automatic logic [WORD_BITS:0] sat_word(input logic signed [SUM_BITS-1:0] v);
      logic [WORD_BITS:0] res;
      if (v > SAT_MAX) begin
         res = {1'b1, WORD_MAX};
      end else if (v < SAT_MIN) begin
         res = {1'b1, WORD_MIN};
      end else begin
         res = {1'b0, v[WORD_BITS-1:0]};
      end
      return res;
   endfunction

endpackage

/* hdl/vec3_vector_alu_unit.sv */
// ----------------------------------------------------------------------------
// vec3_vector_alu_unit: three-component Q16.16 vector ALU
// Every operation passes through every stage on its way to the result strobe;
// throughput one beat per cycle, set by the fully pipelined root
// (16 stages) and the three dividers (24 stages each). busy is never raised
// and the receiver cannot stall. Reset clears only the valid bits.
// ----------------------------------------------------------------------------
module vec3_vector_alu_unit (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   output logic                 busy,
   input  logic [3:0]           req_action,
   input  logic signed [31:0]   req_ax,
   input  logic signed [31:0]   req_ay,
   input  logic signed [31:0]   req_az,
   input  logic signed [31:0]   req_bx,
   input  logic signed [31:0]   req_by,
   input  logic signed [31:0]   req_bz,
   input  logic signed [31:0]   req_scalar_in,
   output logic                 rsp_valid,
   output logic signed [31:0]   rsp_rx,
   output logic signed [31:0]   rsp_ry,
   output logic signed [31:0]   rsp_rz,
   output logic signed [31:0]   rsp_scalar_out,
   output logic                 rsp_div_zero,
   output logic                 rsp_saturated
);

   localparam int WB  = v3alu_pkg::WORD_BITS;
   localparam int FB  = v3alu_pkg::FRAC_BITS;
   localparam int OB  = v3alu_pkg::OPD_BITS;
   localparam int PB  = v3alu_pkg::PROD_BITS;
   localparam int LB  = v3alu_pkg::LANE_BITS;
   localparam int SB  = v3alu_pkg::SUM_BITS;
   localparam int NB  = v3alu_pkg::NUM_BITS;
   localparam int NSQ = v3alu_pkg::SQRT_STAGES;
   localparam int NDV = v3alu_pkg::DIV_STAGES;

   localparam logic signed [OB-1:0] ONE_OPD = OB'(1) <<< FB;
   localparam logic [NB-1:0]        ONE_SQ  = NB'(1) << (2 * FB);
   localparam logic [NB-1:0]        QMAX    = NB'(v3alu_pkg::WORD_MAX);
   localparam logic [NB-1:0]        QMIN    = NB'(v3alu_pkg::WORD_MIN);

   // the pipeline never pushes back
   assign busy = 1'b0;

   // ------------------------------------------------------------------
   // Stage 1: capture the beat; form the saturated difference for dist
   // ------------------------------------------------------------------
   v3alu_pkg::word_type in_a [3];
   v3alu_pkg::word_type in_b [3];
   v3alu_pkg::word_type s1_d_in [3];
   logic                s1_dst_in;

   assign in_a[0] = req_ax;
   assign in_a[1] = req_ay;
   assign in_a[2] = req_az;
   assign in_b[0] = req_bx;
   assign in_b[1] = req_by;
   assign in_b[2] = req_bz;

   always_comb begin
      logic [WB:0] dv;
      s1_dst_in = 1'b0;
      for (int k = 0; k < 3; k++) begin
         dv = v3alu_pkg::sat_word(SB'(in_a[k]) - SB'(in_b[k]));
         s1_d_in[k] = dv[WB-1:0];
         s1_dst_in  = s1_dst_in | dv[WB];
      end
   end

   logic                 s1_vld_ff;
   v3alu_pkg::op_type    s1_act_ff;
   v3alu_pkg::word_type  s1_a_ff [3];
   v3alu_pkg::word_type  s1_b_ff [3];
   v3alu_pkg::word_type  s1_d_ff [3];
   v3alu_pkg::word_type  s1_s_ff;
   logic                 s1_dst_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff <= 1'b0;
      end else begin
         s1_vld_ff <= start & ~busy;
      end
      s1_act_ff <= v3alu_pkg::op_type'(req_action);
      s1_a_ff   <= in_a;
      s1_b_ff   <= in_b;
      s1_d_ff   <= s1_d_in;
      s1_s_ff   <= req_scalar_in;
      s1_dst_ff <= s1_dst_in;
   end

   // ------------------------------------------------------------------
   // Stage 2: pick multiplier operands, multiply; add/sub/sadd finish here
   // Lane k sums products 2k and 2k+1.
   // ------------------------------------------------------------------
   logic signed [OB-1:0] op_a [6];
   logic signed [OB-1:0] op_b [6];
   v3alu_pkg::word_type  s2_r_in [3];
   logic                 s2_st_in;

   always_comb begin
      logic signed [OB-1:0] ea [3];
      logic signed [OB-1:0] eb [3];
      logic signed [OB-1:0] ed [3];
      logic signed [OB-1:0] es;
      logic signed [OB-1:0] oms;
      logic [WB:0]          sv;
      sv = '0;
      for (int k = 0; k < 3; k++) begin
         ea[k] = OB'(s1_a_ff[k]);
         eb[k] = OB'(s1_b_ff[k]);
         ed[k] = OB'(s1_d_ff[k]);
      end
      es  = OB'(s1_s_ff);
      oms = ONE_OPD - es;
      for (int j = 0; j < 6; j++) begin
         op_a[j] = '0;
         op_b[j] = '0;
      end
      for (int k = 0; k < 3; k++) begin
         s2_r_in[k] = '0;
      end
      s2_st_in = 1'b0;
      case (s1_act_ff)
         v3alu_pkg::OP_ADD: begin
            for (int k = 0; k < 3; k++) begin
               sv = v3alu_pkg::sat_word(SB'(s1_a_ff[k]) + SB'(s1_b_ff[k]));
               s2_r_in[k] = sv[WB-1:0];
               s2_st_in   = s2_st_in | sv[WB];
            end
         end
         v3alu_pkg::OP_SUB: begin
            for (int k = 0; k < 3; k++) begin
               sv = v3alu_pkg::sat_word(SB'(s1_a_ff[k]) - SB'(s1_b_ff[k]));
               s2_r_in[k] = sv[WB-1:0];
               s2_st_in   = s2_st_in | sv[WB];
            end
         end
         v3alu_pkg::OP_SADD: begin
            for (int k = 0; k < 3; k++) begin
               sv = v3alu_pkg::sat_word(SB'(s1_a_ff[k]) + SB'(s1_s_ff));
               s2_r_in[k] = sv[WB-1:0];
               s2_st_in   = s2_st_in | sv[WB];
            end
         end
         v3alu_pkg::OP_MUL, v3alu_pkg::OP_DOT: begin
            for (int k = 0; k < 3; k++) begin
               op_a[2*k] = ea[k];
               op_b[2*k] = eb[k];
            end
         end
         v3alu_pkg::OP_SMUL: begin
            for (int k = 0; k < 3; k++) begin
               op_a[2*k] = ea[k];
               op_b[2*k] = es;
            end
         end
         v3alu_pkg::OP_CROSS: begin
            op_a[0] = ea[1];  op_b[0] = eb[2];
            op_a[1] = -ea[2]; op_b[1] = eb[1];
            op_a[2] = ea[2];  op_b[2] = eb[0];
            op_a[3] = -ea[0]; op_b[3] = eb[2];
            op_a[4] = ea[0];  op_b[4] = eb[1];
            op_a[5] = -ea[1]; op_b[5] = eb[0];
         end
         v3alu_pkg::OP_LEN, v3alu_pkg::OP_NORM: begin
            for (int k = 0; k < 3; k++) begin
               op_a[2*k] = ea[k];
               op_b[2*k] = ea[k];
            end
         end
         v3alu_pkg::OP_DIST: begin
            for (int k = 0; k < 3; k++) begin
               op_a[2*k] = ed[k];
               op_b[2*k] = ed[k];
            end
            s2_st_in = s1_dst_ff;
         end
         v3alu_pkg::OP_LERP: begin
            for (int k = 0; k < 3; k++) begin
               op_a[2*k]   = oms;
               op_b[2*k]   = ea[k];
               op_a[2*k+1] = es;
               op_b[2*k+1] = eb[k];
            end
         end
         default: begin
         end
      endcase
   end

   logic                 s2_vld_ff;
   v3alu_pkg::op_type    s2_act_ff;
   logic signed [PB-1:0] s2_p_ff [6];
   v3alu_pkg::word_type  s2_r_ff [3];
   logic                 s2_st_ff;
   v3alu_pkg::word_type  s2_a_ff [3];
   v3alu_pkg::word_type  s2_b_ff [3];

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_vld_ff <= 1'b0;
      end else begin
         s2_vld_ff <= s1_vld_ff;
      end
      s2_act_ff <= s1_act_ff;
      for (int j = 0; j < 6; j++) begin
         s2_p_ff[j] <= op_a[j] * op_b[j];
      end
      s2_r_ff  <= s2_r_in;
      s2_st_ff <= s2_st_in;
      s2_a_ff  <= s1_a_ff;
      s2_b_ff  <= s1_b_ff;
   end

   // ------------------------------------------------------------------
   // Stage 3: lane sums
   // ------------------------------------------------------------------
   logic                 s3_vld_ff;
   v3alu_pkg::op_type    s3_act_ff;
   logic signed [LB-1:0] s3_l_ff [3];
   v3alu_pkg::word_type  s3_r_ff [3];
   logic                 s3_st_ff;
   v3alu_pkg::word_type  s3_a_ff [3];
   v3alu_pkg::word_type  s3_b_ff [3];

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_vld_ff <= 1'b0;
      end else begin
         s3_vld_ff <= s2_vld_ff;
      end
      s3_act_ff <= s2_act_ff;
      for (int k = 0; k < 3; k++) begin
         s3_l_ff[k] <= LB'(s2_p_ff[2*k]) + LB'(s2_p_ff[2*k+1]);
      end
      s3_r_ff  <= s2_r_ff;
      s3_st_ff <= s2_st_ff;
      s3_a_ff  <= s2_a_ff;
      s3_b_ff  <= s2_b_ff;
   end

   // ------------------------------------------------------------------
   // Stage 4: drop the fraction (floor), clamp; total for dot and radicand
   // ------------------------------------------------------------------
   v3alu_pkg::side_type          s4_side_in;
   logic [v3alu_pkg::RAD_BITS-1:0] s4_sq_in;

   always_comb begin
      logic signed [SB-1:0] tot;
      logic [WB:0]          sv;
      sv  = '0;
      tot = SB'(s3_l_ff[0]) + SB'(s3_l_ff[1]) + SB'(s3_l_ff[2]);
      s4_sq_in        = tot[v3alu_pkg::RAD_BITS-1:0];
      s4_side_in.act  = s3_act_ff;
      s4_side_in.so   = '0;
      s4_side_in.st   = s3_st_ff;
      for (int k = 0; k < 3; k++) begin
         s4_side_in.r[k] = s3_r_ff[k];
         s4_side_in.a[k] = s3_a_ff[k];
         s4_side_in.b[k] = s3_b_ff[k];
      end
      case (s3_act_ff)
         v3alu_pkg::OP_MUL, v3alu_pkg::OP_SMUL, v3alu_pkg::OP_CROSS,
         v3alu_pkg::OP_LERP: begin
            for (int k = 0; k < 3; k++) begin
               sv = v3alu_pkg::sat_word(SB'(s3_l_ff[k] >>> FB));
               s4_side_in.r[k] = sv[WB-1:0];
               s4_side_in.st   = s4_side_in.st | sv[WB];
            end
         end
         v3alu_pkg::OP_DOT: begin
            sv = v3alu_pkg::sat_word(tot >>> FB);
            s4_side_in.so = sv[WB-1:0];
            s4_side_in.st = sv[WB];
         end
         default: begin
         end
      endcase
   end

   logic                           s4_vld_ff;
   v3alu_pkg::side_type            s4_side_ff;
   logic [v3alu_pkg::RAD_BITS-1:0] s4_sq_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s4_vld_ff <= 1'b0;
      end else begin
         s4_vld_ff <= s3_vld_ff;
      end
      s4_side_ff <= s4_side_in;
      s4_sq_ff   <= s4_sq_in;
   end

   // ------------------------------------------------------------------
   // Square root, with the beat state held alongside
   // ------------------------------------------------------------------
   logic [v3alu_pkg::ROOT_BITS-1:0] root;
   logic                            sq_vld_ff  [NSQ];
   v3alu_pkg::side_type             sq_side_ff [NSQ];

   v3alu_isqrt u_isqrt (
      .clock    (clock),
      .radicand (s4_sq_ff),
      .root     (root)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NSQ; i++) begin
            sq_vld_ff[i] <= 1'b0;
         end
      end else begin
         sq_vld_ff[0] <= s4_vld_ff;
         for (int i = 1; i < NSQ; i++) begin
            sq_vld_ff[i] <= sq_vld_ff[i-1];
         end
      end
      sq_side_ff[0] <= s4_side_ff;
      for (int i = 1; i < NSQ; i++) begin
         sq_side_ff[i] <= sq_side_ff[i-1];
      end
   end

   // ------------------------------------------------------------------
   // Divider set-up: magnitudes, signs and zero-divisor cases
   // ------------------------------------------------------------------
   v3alu_pkg::side_type sq_out;
   v3alu_pkg::fin_type  dv_fin_in;
   logic [NB-1:0]       dv_num [3];
   logic [WB-1:0]       dv_den [3];
   logic [NB-1:0]       dv_quo [3];

   assign sq_out = sq_side_ff[NSQ-1];

   always_comb begin
      logic [WB-1:0] am;
      logic [WB-1:0] bm;
      logic          an;
      logic          bn;
      dv_fin_in.act   = sq_out.act;
      dv_fin_in.r     = sq_out.r;
      dv_fin_in.so    = sq_out.so;
      dv_fin_in.st    = sq_out.st;
      dv_fin_in.dz    = 1'b0;
      dv_fin_in.neg   = '0;
      dv_fin_in.dzero = '0;
      dv_fin_in.dzneg = '0;
      dv_fin_in.lzero = (root == '0);
      for (int k = 0; k < 3; k++) begin
         an = sq_out.a[k][WB-1];
         bn = sq_out.b[k][WB-1];
         am = an ? (~sq_out.a[k] + WB'(1)) : sq_out.a[k];
         bm = bn ? (~sq_out.b[k] + WB'(1)) : sq_out.b[k];
         dv_num[k] = {am, {FB{1'b0}}};
         dv_den[k] = root;
         case (sq_out.act)
            v3alu_pkg::OP_DIV: begin
               dv_den[k]          = bm;
               dv_fin_in.neg[k]   = an ^ bn;
               dv_fin_in.dzero[k] = (sq_out.b[k] == '0);
               dv_fin_in.dzneg[k] = an;
            end
            v3alu_pkg::OP_INV: begin
               dv_num[k]          = ONE_SQ;
               dv_den[k]          = am;
               dv_fin_in.neg[k]   = an;
               dv_fin_in.dzero[k] = (sq_out.a[k] == '0);
            end
            v3alu_pkg::OP_NORM: begin
               dv_fin_in.neg[k] = an;
            end
            default: begin
            end
         endcase
      end
      if ((sq_out.act == v3alu_pkg::OP_DIV) || (sq_out.act == v3alu_pkg::OP_INV)) begin
         dv_fin_in.dz = |dv_fin_in.dzero;
         dv_fin_in.st = |dv_fin_in.dzero;
      end
      // length and distance take the root as the scalar result
      if ((sq_out.act == v3alu_pkg::OP_LEN) || (sq_out.act == v3alu_pkg::OP_DIST)) begin
         if (root[WB-1]) begin
            dv_fin_in.so = v3alu_pkg::WORD_MAX;
            dv_fin_in.st = 1'b1;
         end else begin
            dv_fin_in.so = root;
         end
      end
   end

   for (genvar g = 0; g < 3; g++) begin : g_lane
      v3alu_div u_div (
         .clock    (clock),
         .dividend (dv_num[g]),
         .divisor  (dv_den[g]),
         .quotient (dv_quo[g])
      );
   end

   logic               dv_vld_ff [NDV];
   v3alu_pkg::fin_type dv_fin_ff [NDV];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NDV; i++) begin
            dv_vld_ff[i] <= 1'b0;
         end
      end else begin
         dv_vld_ff[0] <= sq_vld_ff[NSQ-1];
         for (int i = 1; i < NDV; i++) begin
            dv_vld_ff[i] <= dv_vld_ff[i-1];
         end
      end
      dv_fin_ff[0] <= dv_fin_in;
      for (int i = 1; i < NDV; i++) begin
         dv_fin_ff[i] <= dv_fin_ff[i-1];
      end
   end

   // ------------------------------------------------------------------
   // Final stage: sign the quotients, clamp, pick the lane result
   // ------------------------------------------------------------------
   v3alu_pkg::fin_type  fin;
   v3alu_pkg::word_type out_r_in [3];
   logic                out_st_in;

   assign fin = dv_fin_ff[NDV-1];

   always_comb begin
      logic [NB-1:0] q;
      logic          isdiv;
      out_st_in = fin.st;
      isdiv = (fin.act == v3alu_pkg::OP_DIV) || (fin.act == v3alu_pkg::OP_INV);
      for (int k = 0; k < 3; k++) begin
         q = dv_quo[k];
         out_r_in[k] = fin.r[k];
         if (isdiv && fin.dzero[k]) begin
            out_r_in[k] = fin.dzneg[k] ? v3alu_pkg::WORD_MIN : v3alu_pkg::WORD_MAX;
         end else if ((fin.act == v3alu_pkg::OP_NORM) && fin.lzero) begin
            out_r_in[k] = '0;
         end else if (isdiv || (fin.act == v3alu_pkg::OP_NORM)) begin
            if (fin.neg[k]) begin
               if (q > QMIN) begin
                  out_r_in[k] = v3alu_pkg::WORD_MIN;
                  out_st_in   = 1'b1;
               end else begin
                  out_r_in[k] = ~q[WB-1:0] + WB'(1);
               end
            end else begin
               if (q > QMAX) begin
                  out_r_in[k] = v3alu_pkg::WORD_MAX;
                  out_st_in   = 1'b1;
               end else begin
                  out_r_in[k] = q[WB-1:0];
               end
            end
         end
      end
   end

   logic                out_vld_ff;
   v3alu_pkg::word_type out_r_ff [3];
   v3alu_pkg::word_type out_so_ff;
   logic                out_dz_ff;
   logic                out_st_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_vld_ff <= 1'b0;
      end else begin
         out_vld_ff <= dv_vld_ff[NDV-1];
      end
      out_r_ff  <= out_r_in;
      out_so_ff <= fin.so;
      out_dz_ff <= fin.dz;
      out_st_ff <= out_st_in;
   end

   assign rsp_valid      = out_vld_ff;
   assign rsp_rx         = out_r_ff[0];
   assign rsp_ry         = out_r_ff[1];
   assign rsp_rz         = out_r_ff[2];
   assign rsp_scalar_out = out_so_ff;
   assign rsp_div_zero   = out_dz_ff;
   assign rsp_saturated  = out_st_ff;

endmodule

/* hdl/v3alu_isqrt.sv */
// ----------------------------------------------------------------------------
// v3alu_isqrt: pipelined integer square root
// Floor of the square root of an unsigned radicand, two root bits per stage.
// ----------------------------------------------------------------------------
module v3alu_isqrt (
   input  logic                               clock,
   input  logic [v3alu_pkg::RAD_BITS-1:0]     radicand,
   output logic [v3alu_pkg::ROOT_BITS-1:0]    root
);

   localparam int RB   = v3alu_pkg::ROOT_BITS;
   localparam int RAD  = v3alu_pkg::RAD_BITS;
   localparam int REMB = RB + 4;
   localparam int NST  = v3alu_pkg::SQRT_STAGES;

   logic [RAD-1:0]  rad_ff  [NST];
   logic [REMB-1:0] rem_ff  [NST];
   logic [RB-1:0]   root_ff [NST];

   for (genvar g = 0; g < NST; g++) begin : g_stage
      logic [RAD-1:0]  rad_p;
      logic [REMB-1:0] rem_p;
      logic [RB-1:0]   root_p;
      logic [RAD-1:0]  rad_in;
      logic [REMB-1:0] rem_in;
      logic [RB-1:0]   root_in;

      if (g == 0) begin : g_first
         assign rad_p  = radicand;
         assign rem_p  = '0;
         assign root_p = '0;
      end else begin : g_next
         assign rad_p  = rad_ff[g-1];
         assign rem_p  = rem_ff[g-1];
         assign root_p = root_ff[g-1];
      end

      always_comb begin
         logic [RAD-1:0]  sv;
         logic [REMB-1:0] rv;
         logic [REMB-1:0] tv;
         logic [RB-1:0]   qv;
         sv = rad_p;
         rv = rem_p;
         qv = root_p;
         for (int i = 0; i < 2; i++) begin
            // bring down two radicand bits, try root*4+1
            rv = {rv[REMB-3:0], sv[RAD-1 -: 2]};
            sv = {sv[RAD-3:0], 2'b00};
            tv = {2'b00, qv, 2'b01};
            if (rv >= tv) begin
               rv = rv - tv;
               qv = {qv[RB-2:0], 1'b1};
            end else begin
               qv = {qv[RB-2:0], 1'b0};
            end
         end
         rad_in  = sv;
         rem_in  = rv;
         root_in = qv;
      end

      always_ff @(posedge clock) begin
         rad_ff[g]  <= rad_in;
         rem_ff[g]  <= rem_in;
         root_ff[g] <= root_in;
      end
   end

   assign root = root_ff[NST-1];

endmodule

/* hdl/v3alu_div.sv */
// ----------------------------------------------------------------------------
// v3alu_div: pipelined unsigned divider
// Restoring long division, two quotient bits per stage.
// ----------------------------------------------------------------------------
module v3alu_div (
   input  logic                               clock,
   input  logic [v3alu_pkg::NUM_BITS-1:0]     dividend,
   input  logic [v3alu_pkg::WORD_BITS-1:0]    divisor,
   output logic [v3alu_pkg::NUM_BITS-1:0]     quotient
);

   localparam int NB  = v3alu_pkg::NUM_BITS;
   localparam int DB  = v3alu_pkg::WORD_BITS;
   localparam int NST = v3alu_pkg::DIV_STAGES;

   logic [NB-1:0] w_ff [NST];   // dividend bits left, quotient bits shifted in
   logic [DB-1:0] r_ff [NST];
   logic [DB-1:0] d_ff [NST];

   for (genvar g = 0; g < NST; g++) begin : g_stage
      logic [NB-1:0] w_p;
      logic [DB-1:0] r_p;
      logic [DB-1:0] d_p;
      logic [NB-1:0] w_in;
      logic [DB-1:0] r_in;

      if (g == 0) begin : g_first
         assign w_p = dividend;
         assign r_p = '0;
         assign d_p = divisor;
      end else begin : g_next
         assign w_p = w_ff[g-1];
         assign r_p = r_ff[g-1];
         assign d_p = d_ff[g-1];
      end

      always_comb begin
         logic [NB-1:0] wv;
         logic [DB:0]   rv;
         logic          qb;
         wv = w_p;
         rv = {1'b0, r_p};
         for (int i = 0; i < 2; i++) begin
            rv = {rv[DB-1:0], wv[NB-1]};
            qb = (rv >= {1'b0, d_p});
            if (qb) begin
               rv = rv - {1'b0, d_p};
            end
            wv = {wv[NB-2:0], qb};
         end
         w_in = wv;
         r_in = rv[DB-1:0];
      end

      always_ff @(posedge clock) begin
         w_ff[g] <= w_in;
         r_ff[g] <= r_in;
         d_ff[g] <= d_p;
      end
   end

   assign quotient = w_ff[NST-1];

endmodule
